>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion violated");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_CLK(lbl, clk, rst, !(cond))

`endif

>>> design/pidg_pkg.sv
// Types, constants and helper functions for the gyro damped PID block.
package pidg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_KP       = 3'd1;
  localparam logic [2:0] REG_KI       = 3'd2;
  localparam logic [2:0] REG_KD       = 3'd3;
  localparam logic [2:0] REG_KG       = 3'd4;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  // Control law constants.
  localparam logic signed [31:0] DRIVE_LIMIT = 32'sd15000;
  localparam logic [16:0]        SEP_BAND    = 17'd300;
  localparam logic [16:0]        FULL_BAND   = 17'd100;
  localparam logic [8:0]         WEIGHT_ONE  = 9'd256;
  // 2^17 / 25 rounded up; exact floor for numerators up to 6400.
  localparam logic [12:0]        RECIP_25    = 13'd5243;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // Taper weight floor((300 - mag) * 256 / 200) for mag in 100..300.
  function automatic logic [8:0] taper_weight(input logic [16:0] mag);
    logic [8:0]  x;
    logic [12:0] v;
    logic [25:0] p;
    x = 9'(SEP_BAND - mag);
    v = {x[7:0], 5'b00000};
    p = {13'b0, v} * {13'b0, RECIP_25};
    return p[25:17];
  endfunction

endpackage

>>> design/pidg_mul.sv
// Shared signed multiplier with a registered product.
module pidg_mul (
  input  logic             clk,
  input  pidg_pkg::mul_a_t op_a,
  input  pidg_pkg::mul_b_t op_b,
  output pidg_pkg::prod_t  prod
);

  always_ff @(posedge clk) begin
    prod <= pidg_pkg::PROD_W'(op_a) * pidg_pkg::PROD_W'(op_b);
  end

endmodule

>>> design/pid_variable_integral_gyro_damped.sv
// Top level of the PID controller with variable integral gain and gyro damping.
//
// Use: configure setpoint, kp, ki, kd and kg through the cfg channel
// (cfg_index 0..4, cfg_data 16-bit two's complement; other indexes are
// dropped; cfg_ready is always high). Write them only while the block is idle.
// Each control tick, present measured and gyro_rate with in_valid; the item
// transfers on a clock edge with in_valid high and in_stall low. One drive
// value comes back per item on the output channel, transferred on an edge
// with out_valid high and out_stall low.
// The input stays closed (in_stall high) from the transfer until the sequencer
// hands the drive to the output register; the single shared 25x32 multiplier,
// used five times per item under the sequencer, is why items cannot overlap.
// The finished drive sits in an output register, so the next item is taken
// while it waits; if the receiver stalls so long that the next result is
// ready too, the sequencer holds in its last step until the register frees.
// Reset clears the gains, setpoint, integral, last error and last drive to
// zero and empties the output register.
module pid_variable_integral_gyro_damped #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] measured,
  input  logic signed [15:0] gyro_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drive,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int SHIFT = GAIN_FRAC_BITS + 9;
  localparam int ACC_W = pidg_pkg::ACC_W;

  // Sequencer steps.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;  // form the error
  localparam logic [3:0] S_WGT  = 4'd2;  // weight, integral, issue kp*e
  localparam logic [3:0] S_M1   = 4'd3;  // issue kd*de, add kp*e
  localparam logic [3:0] S_M2   = 4'd4;  // issue kg*gyro, add kd*de
  localparam logic [3:0] S_M3   = 4'd5;  // issue ki*w, add kg*gyro
  localparam logic [3:0] S_M4   = 4'd6;  // issue (ki*w)*integral
  localparam logic [3:0] S_M5   = 4'd7;  // add weighted integral term
  localparam logic [3:0] S_FIN  = 4'd8;  // floor, saturate, hand off

  logic [3:0] state, state_next;

  logic signed [15:0] setpoint, kp, ki, kd, kg;
  logic signed [15:0] meas_r, gyro_r;
  logic signed [16:0] e_r;
  logic signed [17:0] de_r;
  logic [8:0]         w_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] error_sum, previous_drive;
  logic signed [16:0] previous_error;

  pidg_pkg::mul_a_t op_a;
  pidg_pkg::mul_b_t op_b;
  pidg_pkg::prod_t  prod;

  logic [16:0]        mag;
  logic               far, drv_high, drv_low, e_neg, e_pos, add_e;
  logic [8:0]         weight;
  logic signed [32:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic signed [ACC_W-1:0] prod_ext, shifted;
  logic signed [31:0] drive_sat;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      kp       <= '0;
      ki       <= '0;
      kd       <= '0;
      kg       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidg_pkg::REG_SETPOINT: setpoint <= cfg_data;
        pidg_pkg::REG_KP:       kp       <= cfg_data;
        pidg_pkg::REG_KI:       ki       <= cfg_data;
        pidg_pkg::REG_KD:       kd       <= cfg_data;
        pidg_pkg::REG_KG:       kg       <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Integral weight selection: separation, conditional anti-windup, taper.
  always_comb begin
    mag      = e_r[16] ? 17'(-e_r) : 17'(e_r);
    e_neg    = e_r[16];
    e_pos    = !e_r[16] && (e_r != '0);
    far      = mag > pidg_pkg::SEP_BAND;
    drv_high = previous_drive > pidg_pkg::DRIVE_LIMIT;
    drv_low  = previous_drive < -pidg_pkg::DRIVE_LIMIT;
    weight   = '0;
    add_e    = 1'b0;
    if (far) begin
      weight = '0;
    end else if (drv_high) begin
      if (e_neg) begin
        weight = pidg_pkg::WEIGHT_ONE;
        add_e  = 1'b1;
      end
    end else if (drv_low) begin
      if (e_pos) begin
        weight = pidg_pkg::WEIGHT_ONE;
        add_e  = 1'b1;
      end
    end else if (mag < pidg_pkg::FULL_BAND) begin
      weight = pidg_pkg::WEIGHT_ONE;
      add_e  = 1'b1;
    end else begin
      weight = pidg_pkg::taper_weight(mag);
      add_e  = 1'b1;
    end
    // Saturating integral update.
    sum_ext = {error_sum[31], error_sum} + 33'(e_r);
    if (sum_ext[32] != sum_ext[31]) begin
      sum_sat = sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_ext[31:0];
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_WGT: begin
        op_a = pidg_pkg::MUL_A_W'(kp);
        op_b = pidg_pkg::MUL_B_W'(e_r);
      end
      S_M1: begin
        op_a = pidg_pkg::MUL_A_W'(kd);
        op_b = pidg_pkg::MUL_B_W'(de_r);
      end
      S_M2: begin
        op_a = pidg_pkg::MUL_A_W'(kg);
        op_b = pidg_pkg::MUL_B_W'(gyro_r);
      end
      S_M3: begin
        op_a = pidg_pkg::MUL_A_W'(ki);
        op_b = pidg_pkg::MUL_B_W'({1'b0, w_r});
      end
      S_M4: begin
        op_a = prod[pidg_pkg::MUL_A_W-1:0];
        op_b = error_sum;
      end
      default: ;
    endcase
  end

  pidg_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Floor to integer, then saturate to signed 32 bits.
  always_comb begin
    prod_ext = ACC_W'(prod);
    shifted  = acc >>> SHIFT;
    if (shifted[ACC_W-1:31] == {(ACC_W-31){shifted[ACC_W-1]}}) begin
      drive_sat = shifted[31:0];
    end else begin
      drive_sat = shifted[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_ERR;
      S_ERR:  state_next = S_WGT;
      S_WGT:  state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_M4;
      S_M4:   state_next = S_M5;
      S_M5:   state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller state: integral, last error, last drive.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      previous_drive <= '0;
    end else begin
      if (state == S_WGT && add_e) error_sum <= sum_sat;
      if (state == S_FIN && out_free) begin
        previous_error <= e_r;
        previous_drive <= drive_sat;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      meas_r <= measured;
      gyro_r <= gyro_rate;
    end
    if (state == S_ERR) e_r <= 17'(meas_r) - 17'(setpoint);
    if (state == S_WGT) begin
      de_r <= 18'(e_r) - 18'(previous_error);
      w_r  <= weight;
    end
    unique case (state) inside
      S_WGT:             acc <= '0;
      S_M1, S_M2, S_M3:  acc <= acc + (prod_ext <<< 9);
      S_M5:              acc <= acc + prod_ext;
      default: ;
    endcase
  end

  // Output register: load on finish, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) drive <= drive_sat;
  end

endmodule

>>> design/pidg_checker.sv
// Port-level checker for the gyro damped PID block, bound to the top level.
`include "assert_macros.svh"

module pidg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] drive,
  input logic        cfg_ready
);

  // Hold a stalled result.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  `ASSERT_CLK(a_drive_hold, clk, rst, out_valid && out_stall |=> $stable(drive))
  // The sequencer keeps the input closed for the whole computation.
  `ASSERT_CLK(a_busy_after_take, clk, rst, in_valid && !in_stall |=> ##6 in_stall)
  // A new result only appears out of a busy computation.
  `ASSERT_CLK(a_result_from_work, clk, rst, $rose(out_valid) |-> $past(in_stall))
  // The configuration channel never refuses a write.
  `ASSERT_NEVER(a_cfg_open, clk, rst, !cfg_ready)

endmodule

bind pid_variable_integral_gyro_damped pidg_checker u_pidg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .cfg_ready (cfg_ready)
);

>>> test/pid_variable_integral_gyro_damped_tb.sv
// Self-checking bench for the gyro damped PID controller with variable integral weight.
module pid_variable_integral_gyro_damped_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAIN_FRAC_BITS = 8;
  // Gains carry GAIN_FRAC_BITS fraction bits, the weight 8 more, the halving one more.
  localparam int DRIVE_SHIFT = GAIN_FRAC_BITS + 9;

  localparam longint WINDUP_LIMIT = 15000;
  localparam longint SEP_LIMIT    = 300;
  localparam longint NEAR_LIMIT   = 100;
  localparam longint TAPER_SPAN   = 200;
  localparam longint UNITY_WEIGHT = 256;
  localparam longint S32_MAX      = 64'sd2147483647;
  localparam longint S32_MIN      = -64'sd2147483648;

  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int PHASES        = 10;
  localparam int PHASE_TICKS   = 120;

  // How wide a random gain setting is allowed to roam.
  typedef enum int {
    GAINS_EXTREME,
    GAINS_SMALL,
    GAINS_MEDIUM,
    GAINS_FULL
  } gain_span_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] measured = '0;
  logic signed [15:0] gyro_rate = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] drive;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // Expected drive values, oldest first.
  logic signed [31:0] drive_queue[$];

  // Shadow copy of the controller: registers and loop state.
  logic signed [15:0] setpoint_r = '0;
  logic signed [15:0] kp_r = '0;
  logic signed [15:0] ki_r = '0;
  logic signed [15:0] kd_r = '0;
  logic signed [15:0] kg_r = '0;
  longint             integ = 0;
  longint             last_err = 0;
  longint             last_drive = 0;

  // Run bookkeeping.
  int fail_count = 0;
  int results_seen = 0;
  int ticks = 0;
  int gain_sets = 0;
  int separated = 0;
  int tapered = 0;
  int windup_holds = 0;
  int cycle_count = 0;

  // Receiver side back-pressure control.
  logic quiet = 1'b0;
  int   hold_ticket = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  int band_edges[8] = '{-301, -300, -100, -99, 99, 100, 300, 301};

  pid_variable_integral_gyro_damped #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .measured (measured),
    .gyro_rate(gyro_rate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive    (drive),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive values outstanding", cycle_count,
               drive_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void log_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Advance the shadow controller by one tick and return the drive it should produce.
  function automatic logic signed [31:0] predict_drive(input logic signed [15:0] m,
                                                       input logic signed [15:0] g);
    longint err;
    longint mag;
    longint weight;
    longint pdg;
    longint total;
    longint d;
    bit     integrate;
    err = longint'(m) - longint'(setpoint_r);
    mag = (err < 0) ? -err : err;
    weight = 0;
    integrate = 1'b0;
    ticks++;
    if (mag > SEP_LIMIT) begin
      // Integral separation: far from target the integral is frozen and unweighted.
      separated++;
    end else if (last_drive > WINDUP_LIMIT) begin
      // Saturated high: only errors that pull the drive down get integrated.
      if (err < 0) begin
        weight = UNITY_WEIGHT;
        integrate = 1'b1;
      end else begin
        windup_holds++;
      end
    end else if (last_drive < -WINDUP_LIMIT) begin
      if (err > 0) begin
        weight = UNITY_WEIGHT;
        integrate = 1'b1;
      end else begin
        windup_holds++;
      end
    end else if (mag < NEAR_LIMIT) begin
      weight = UNITY_WEIGHT;
      integrate = 1'b1;
    end else begin
      // Linear taper from full weight at the inner edge to zero at the separation edge.
      weight = ((SEP_LIMIT - mag) * UNITY_WEIGHT) / TAPER_SPAN;
      integrate = 1'b1;
      tapered++;
    end
    if (integrate) integ = clamp32(integ + err);
    pdg = longint'(kp_r) * err + longint'(kd_r) * (err - last_err) + longint'(kg_r) * longint'(g);
    total = pdg * 512 + weight * longint'(ki_r) * integ;
    d = clamp32(total >>> DRIVE_SHIFT);
    last_err = err;
    last_drive = d;
    return 32'(d);
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      pidg_pkg::REG_SETPOINT: setpoint_r = val;
      pidg_pkg::REG_KP:       kp_r = val;
      pidg_pkg::REG_KI:       ki_r = val;
      pidg_pkg::REG_KD:       kd_r = val;
      pidg_pkg::REG_KG:       kg_r = val;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain(input gain_span_t span);
    int pick;
    pick = $urandom_range(0, 3);
    case (span)
      GAINS_EXTREME: begin
        if (pick == 0) return 16'h7fff;
        if (pick == 1) return 16'h8000;
        if (pick == 2) return 16'h0000;
        return 16'($urandom);
      end
      GAINS_SMALL:  return 16'(int'($urandom_range(0, 1024)) - 512);
      GAINS_MEDIUM: return 16'(int'($urandom_range(0, 16000)) - 8000);
      default:      return 16'($urandom);
    endcase
  endfunction

  // Leave cfg_valid high on return; the caller drops it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, val);
  endtask

  task automatic load_gains(input logic [15:0] sp, input logic [15:0] p, input logic [15:0] i,
                            input logic [15:0] d, input logic [15:0] g);
    write_reg(pidg_pkg::REG_SETPOINT, sp);
    write_reg(pidg_pkg::REG_KP, p);
    write_reg(pidg_pkg::REG_KI, i);
    write_reg(pidg_pkg::REG_KD, d);
    write_reg(pidg_pkg::REG_KG, g);
    cfg_valid <= 1'b0;
    gain_sets++;
  endtask

  // Offer one tick, maybe after a random gap; return at the edge that takes it.
  // in_valid stays high, so the caller sends again or drains in the same step.
  task automatic send_sample(input logic signed [15:0] m, input logic signed [15:0] g);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    measured  <= m;
    gyro_rate <= g;
    do @(posedge clk); while (in_stall);
    drive_queue.push_back(predict_drive(m, g));
  endtask

  // Mostly errors inside or around the integral band, some fully random ticks.
  task automatic send_random_sample();
    int                 pick;
    int                 off;
    logic signed [15:0] m;
    logic signed [15:0] g;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      off = int'($urandom_range(0, 700)) - 350;
      m = 16'(int'(setpoint_r) + off);
    end else if (pick == 7) begin
      m = 16'(int'(setpoint_r) + band_edges[$urandom_range(0, 7)]);
    end else begin
      m = 16'($urandom);
    end
    if ($urandom_range(0, 1) == 0) g = 16'($urandom);
    else g = 16'(int'($urandom_range(0, 1024)) - 512);
    send_sample(m, g);
  endtask

  // Drop valid and hold until every expected drive has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Band edges: near, taper and separation boundaries on both signs, plus field extremes.
  task automatic test_band_edges();
    int offs[13] = '{0, 99, 100, 101, 150, 299, 300, 301, -99, -100, -250, -300, -301};
    // Gains are still zero out of reset, so the drive must be zero.
    send_sample(16'sh1234, 16'sh4321);
    wait_drained();
    load_gains(16'sd1000, 16'sd256, 16'sd256, 16'sd256, 16'sd256);
    foreach (offs[k]) send_sample(16'(1000 + offs[k]), 16'(offs[k]));
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    wait_drained();
  endtask

  // Anti-windup: push the drive past the limit each way and probe both error signs.
  task automatic test_windup();
    int offs[7] = '{200, 150, -50, -200, -10, 20, 0};
    // Indexes past the last register address nothing; the shadow ignores them too.
    for (int k = 1; k <= 3; k++) write_reg(3'(pidg_pkg::REG_KG + k), 16'($urandom));
    load_gains(16'sd0, 16'sh7fff, 16'sd256, 16'sd0, 16'sd0);
    foreach (offs[k]) send_sample(16'(offs[k]), 16'sd0);
    wait_drained();
  endtask

  // Random phases, each under a fresh gain setting; the first two pin the extremes.
  task automatic test_random_sweep();
    gain_span_t span;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        load_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      end else if (ph == 1) begin
        load_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      end else begin
        span = gain_span_t'($urandom_range(0, 3));
        load_gains(pick_gain(($urandom_range(0, 3) == 0) ? GAINS_EXTREME : GAINS_FULL),
                   pick_gain(span), pick_gain(span), pick_gain(span), pick_gain(span));
      end
      repeat (PHASE_TICKS) send_random_sample();
      wait_drained();
    end
  endtask

  // Long receiver hold while ticks keep coming, then a full pause of the sender.
  task automatic test_backpressure();
    load_gains(16'($urandom), pick_gain(GAINS_MEDIUM), pick_gain(GAINS_MEDIUM),
               pick_gain(GAINS_MEDIUM), pick_gain(GAINS_MEDIUM));
    hold_ticket <= hold_ticket + 1;
    repeat (24) send_random_sample();
    wait_drained();
    repeat (24) send_random_sample();
    wait_drained();
  endtask

  // Back-to-back ticks with no idling on either side.
  task automatic test_steady_stream();
    quiet <= 1'b1;
    load_gains(16'($urandom), pick_gain(GAINS_SMALL), pick_gain(GAINS_SMALL),
               pick_gain(GAINS_SMALL), pick_gain(GAINS_SMALL));
    repeat (100) send_random_sample();
  endtask

  // Receiver: random stall bursts, plus a long hold on request from the stimulus.
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each drive transfer against the oldest expectation.
  always @(posedge clk) begin : check_drive
    logic signed [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (drive_queue.size() == 0) begin
        log_mismatch($sformatf("drive %0d transferred with nothing pending", drive));
      end else begin
        want = drive_queue.pop_front();
        results_seen++;
        if (drive !== want)
          log_mismatch($sformatf("drive expected %0d, got %0d", want, drive));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_band_edges();
    test_windup();
    test_random_sweep();
    test_backpressure();
    test_steady_stream();

    // Drain with a bound, then give a stray extra drive time to show up.
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && drive_queue.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_queue.size() != 0)
      log_mismatch($sformatf("%0d drive values never arrived", drive_queue.size()));

    $display("Covered %0d control ticks over %0d gain settings; %0d drive transfers checked.",
             ticks, gain_sets, results_seen);
    $display("Integral paths: %0d separated, %0d tapered, %0d held by anti-windup; %0d failures.",
             separated, tapered, windup_holds, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
